@@ sv/sid_pkg.sv @@
// shared types and constants for the signed integer to decimal ascii unit
package sid_pkg;

  localparam int DIGIT_BITS = 4;

  typedef logic [DIGIT_BITS-1:0] digit_t;
  typedef logic [6:0]            ascii_t;

  localparam ascii_t ASCII_ZERO  = 7'd48;
  localparam ascii_t ASCII_MINUS = 7'd45;

  localparam digit_t DIGIT_FIVE  = 4'd5;
  localparam digit_t DIGIT_THREE = 4'd3;

endpackage

@@ sv/sid_dabble.sv @@
// bit-serial binary to bcd converter, shift and add-three, one bit per cycle
module sid_dabble #(
  parameter int VALUE_BITS = 32,
  parameter int DIGITS     = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [VALUE_BITS-1:0]                 mag_in,
  output logic                                  busy,
  output logic [DIGITS*sid_pkg::DIGIT_BITS-1:0] bcd
);
  import sid_pkg::*;

  localparam int BCD_W = DIGITS * DIGIT_BITS;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] mag;
  logic [CNT_W-1:0]      count;
  logic [BCD_W-1:0]      bcd_adj;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*DIGIT_BITS +: DIGIT_BITS] >= DIGIT_FIVE) begin
        bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd[i*DIGIT_BITS +: DIGIT_BITS] + DIGIT_THREE;
      end else begin
        bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd[i*DIGIT_BITS +: DIGIT_BITS];
      end
    end
  end

  assign busy = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(VALUE_BITS);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag <= mag_in;
      bcd <= '0;
    end else if (busy) begin
      mag <= mag << 1;
      bcd <= {bcd_adj[BCD_W-2:0], mag[VALUE_BITS-1]};
    end
  end

endmodule

@@ sv/sid_emit.sv @@
// character sequencer: sign, leading zero skip and output register
module sid_emit #(
  parameter int DIGITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  logic                                  load_neg,
  input  logic [DIGITS*sid_pkg::DIGIT_BITS-1:0] load_bcd,
  output logic                                  idle,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [6:0]                            char_code,
  output logic                                  is_last
);
  import sid_pkg::*;

  localparam int BCD_W = DIGITS * DIGIT_BITS;
  localparam int CNT_W = $clog2(DIGITS + 1);

  logic [BCD_W-1:0] digs;
  logic [CNT_W-1:0] remain;
  logic             sign_pend;
  logic             started;
  logic             slot_free;
  logic             skip;
  logic             emit_char;
  digit_t           top_dig;

  assign top_dig   = digs[BCD_W-1 -: DIGIT_BITS];
  assign slot_free = !out_valid || out_ready;
  assign idle      = (remain == '0) && !sign_pend;
  // leading zero, but never the final digit
  assign skip      = !started && (top_dig == '0) && (remain != CNT_W'(1));
  // a character goes into the output register this cycle
  assign emit_char = !load && (sign_pend ? slot_free
                                         : (remain != '0 && !skip && slot_free));

  always_ff @(posedge clk) begin
    if (rst) begin
      remain    <= '0;
      sign_pend <= 1'b0;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit_char || (out_valid && !out_ready);
      if (load) begin
        remain    <= CNT_W'(DIGITS);
        sign_pend <= load_neg;
        started   <= 1'b0;
      end else if (sign_pend) begin
        if (slot_free) begin
          sign_pend <= 1'b0;
        end
      end else if (remain != '0) begin
        if (skip) begin
          remain <= remain - 1'b1;
        end else if (slot_free) begin
          remain    <= remain - 1'b1;
          started   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digs <= load_bcd;
    end else if (!sign_pend && remain != '0) begin
      if (skip || slot_free) begin
        digs <= digs << DIGIT_BITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!load && sign_pend && slot_free) begin
      char_code <= ASCII_MINUS;
      is_last   <= 1'b0;
    end else if (!load && !sign_pend && remain != '0 && !skip && slot_free) begin
      char_code <= ASCII_ZERO + {3'b000, top_dig};
      is_last   <= (remain == CNT_W'(1));
    end
  end

endmodule

@@ sv/signed_int_to_decimal_ascii_unit.sv @@
// top level of the signed integer to decimal ascii unit
//
// input channel: one transaction carries a signed two's complement value
// (in_valid, in_ready, value). output channel: one transaction per ascii
// character (out_valid, out_ready, char_code, is_last), most significant
// first, a leading '-' for negative values, no leading zeros, zero as a
// single '0', is_last set on the final digit, no terminator.
// the magnitude is converted to bcd one bit per cycle by a shift and
// add-three register. the digit register is then walked one digit per
// cycle unless a stalled receiver holds a character, leading zeros
// dropped without output. the dabble loop and the digit walk take up
// most of the time an item spends in the unit.
// the first character is offered once the dabble loop has drained and
// the digits are loaded into the sequencer; for a positive value the
// leading zeros are dropped first.
// a stalled receiver holds the character in the output register and
// freezes the digit walk; the next value can be taken and converted
// while the final character of the previous one still waits.
// reset (synchronous, active high) empties both channels and drops any
// item in flight.
module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [6:0]                   char_code,
  output logic                         is_last
);
  import sid_pkg::*;

  // decimal digits of the largest magnitude, 2^(VALUE_BITS-1)
  localparam int DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BCD_W  = DIGITS * DIGIT_BITS;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                state, state_next;
  logic                  neg;
  logic                  accept;
  logic [VALUE_BITS-1:0] mag_abs;
  logic                  dab_busy;
  logic [BCD_W-1:0]      bcd;
  logic                  emit_load;
  logic                  emit_idle;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // magnitude as unsigned, the most negative value maps to 2^(VALUE_BITS-1)
  assign mag_abs = value[VALUE_BITS-1]
                 ? ($unsigned(~value) + {{(VALUE_BITS-1){1'b0}}, 1'b1})
                 : $unsigned(value);

  // hand the digits to the sequencer once the dabble loop has drained
  assign emit_load = (state == ST_CONV) && !dab_busy;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (!dab_busy) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // the last character may still sit in the output register
        if (emit_idle) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= value[VALUE_BITS-1];
    end
  end

  sid_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_dabble (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .mag_in (mag_abs),
    .busy   (dab_busy),
    .bcd    (bcd)
  );

  sid_emit #(
    .DIGITS (DIGITS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (emit_load),
    .load_neg  (neg),
    .load_bcd  (bcd),
    .idle      (emit_idle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .is_last   (is_last)
  );

endmodule
